[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the partitioner. Each use
// sits on a line of its own and expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SAPB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SAPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sapb_pkg.sv]
// ----------------------------------------------------------------------------
// Partitioner package
// Request codes, register map and sizing constants of the adaptive
// partition and borrow unit.
// ----------------------------------------------------------------------------
package sapb_pkg;

    // Structure size the register total_entries is clipped to.
    localparam int unsigned ENTRIES = 128;
    localparam int unsigned THREADS = 2;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register reset values.
    localparam logic [7:0]  TOTAL_RESET     = 8'd128;
    localparam logic [7:0]  STEP_RESET      = 8'd4;
    localparam logic [7:0]  MAX_ALLOW_RESET = 8'd128;
    localparam logic [19:0] INTERVAL_RESET  = 20'd10000;
    localparam logic        MAIN_RESET      = 1'b0;
    localparam logic [7:0]  MAX_BORROW_RESET = 8'd8;
    localparam logic [7:0]  MIN_FREE_RESET  = 8'd10;

    // Partition limit after reset: half of the clipped reset size.
    localparam int unsigned EFF_RESET = (128 > ENTRIES) ? ENTRIES : 128;
    localparam logic [7:0]  LIMIT_RESET = 8'(EFF_RESET / THREADS);

    typedef enum logic [2:0] {
        REQ_CONSUME    = 3'd0,
        REQ_FREE       = 3'd1,
        REQ_IS_FULL    = 3'd2,
        REQ_FREE_COUNT = 3'd3,
        REQ_RESET_PART = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        REG_TOTAL      = 3'd0,
        REG_STEP       = 3'd1,
        REG_MAX_ALLOW  = 3'd2,
        REG_INTERVAL   = 3'd3,
        REG_MAIN       = 3'd4,
        REG_MAX_BORROW = 3'd5,
        REG_MIN_FREE   = 3'd6
    } reg_idx_t;

endpackage

[hdl/smt_adaptive_partition_borrow_unit.sv]
// ----------------------------------------------------------------------------
// Adaptive partition and borrow unit
// Two-thread partitioner for one shared pipeline structure, with borrowing
// by the non-main thread and interval-based partition adaptation.
// ----------------------------------------------------------------------------
// Usage.
// The request channel (in_valid, in_stall) carries one beat per request:
// req_type, thread_id and cycle_now. The result channel (out_valid,
// out_stall) returns exactly one beat per request, in order, holding the
// query answers and the partition state as it stands after that request.
// A request beat is captured in an input register; from there the whole
// update is worked out by a single layer of logic from the state registers
// and written, together with the result, into the result register once it
// is empty or being drained. One request is taken every cycle for as long
// as the result side keeps accepting. The only loop is the state update
// itself, closed through the state registers alone, so back-to-back requests
// see each other's effects. When the receiver stalls, the result register
// holds its beat, one more request waits in the input register, and in_stall
// is raised after that. Reset clears both channels, restores the register
// defaults, empties the occupancy counts and sets both limits to half the
// structure size. Registers are to be written by the user through the APB
// port only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smt_adaptive_partition_borrow_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sapb_pkg::ADDR_W-1:0]  paddr,
    input  logic [sapb_pkg::DATA_W-1:0]  pwdata,
    output logic [sapb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // Request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   req_type,
    input  logic                         thread_id,
    input  logic [31:0]                  cycle_now,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         full_flag,
    output logic [7:0]                   free_entries,
    output logic                         borrowed_from_main,
    output logic [31:0]                  squash_events,
    output logic [31:0]                  borrow_events,
    output logic [7:0]                   limit_thread0,
    output logic [7:0]                   limit_thread1
);
    import sapb_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  total_entries_reg;
    logic [7:0]  step_entries_reg;
    logic [7:0]  max_allowed_reg;
    logic [19:0] adapt_interval_reg;
    logic        main_thread_reg;
    logic [7:0]  max_borrow_reg;
    logic [7:0]  min_free_reg;

    logic        cfg_write;
    logic [2:0]  cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_entries_reg  <= TOTAL_RESET;
            step_entries_reg   <= STEP_RESET;
            max_allowed_reg    <= MAX_ALLOW_RESET;
            adapt_interval_reg <= INTERVAL_RESET;
            main_thread_reg    <= MAIN_RESET;
            max_borrow_reg     <= MAX_BORROW_RESET;
            min_free_reg       <= MIN_FREE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_TOTAL:      total_entries_reg  <= pwdata[7:0];
                REG_STEP:       step_entries_reg   <= pwdata[7:0];
                REG_MAX_ALLOW:  max_allowed_reg    <= pwdata[7:0];
                REG_INTERVAL:   adapt_interval_reg <= pwdata[19:0];
                REG_MAIN:       main_thread_reg    <= pwdata[0];
                REG_MAX_BORROW: max_borrow_reg     <= pwdata[7:0];
                REG_MIN_FREE:   min_free_reg       <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TOTAL:      prdata = {24'd0, total_entries_reg};
            REG_STEP:       prdata = {24'd0, step_entries_reg};
            REG_MAX_ALLOW:  prdata = {24'd0, max_allowed_reg};
            REG_INTERVAL:   prdata = {12'd0, adapt_interval_reg};
            REG_MAIN:       prdata = {31'd0, main_thread_reg};
            REG_MAX_BORROW: prdata = {24'd0, max_borrow_reg};
            REG_MIN_FREE:   prdata = {24'd0, min_free_reg};
            default:        prdata = '0;
        endcase
    end

    // Half of the structure size in use, after clipping to ENTRIES.
    logic [8:0] eff_size;
    logic [7:0] half_size;

    assign eff_size  = ({1'b0, total_entries_reg} > 9'(ENTRIES)) ? 9'(ENTRIES)
                                                                 : {1'b0, total_entries_reg};
    assign half_size = eff_size[8:1];

    // ------------------------------------------------------------------
    // Input register and flow control
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [2:0]  req_reg;
    logic        tid_reg;
    logic [31:0] now_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        fire;

    // The result register may be refilled when empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= req_type;
            tid_reg <= thread_id;
            now_reg <= cycle_now;
        end
    end

    // ------------------------------------------------------------------
    // Partition state
    // ------------------------------------------------------------------
    logic [8:0]  occ0_reg, occ1_reg, occ0_next, occ1_next;
    logic [7:0]  lim0_reg, lim1_reg, lim0_next, lim1_next;
    logic [15:0] tal0_reg, tal1_reg, tal0_next, tal1_next;
    logic [31:0] last_adapt_reg, last_adapt_next;
    logic [7:0]  borrowed_reg, borrowed_next;
    logic        squashing_reg, squashing_next;
    logic [31:0] squash_tally_reg, squash_tally_next;
    logic [31:0] borrow_tally_reg, borrow_tally_next;
    logic        full_next;
    logic [7:0]  nfree_next;

    always_comb
    begin
        logic [8:0]         occ_v [2];
        logic [7:0]         lim_v [2];
        logic [15:0]        tal_v [2];
        logic [31:0]        la_v;
        logic [7:0]         bor_v;
        logic               sqg_v;
        logic [31:0]        sqt_v;
        logic [31:0]        bt_v;
        logic               tid;
        logic               mt;
        logic [8:0]         occ_tid;
        logic [7:0]         lim_tid;
        logic               at_lim;
        logic [32:0]        deadline;
        logic               grow;
        logic               shrink;
        logic [8:0]         grown;
        logic signed [10:0] spare_main;
        logic signed [10:0] min_s;
        logic signed [10:0] lend;
        logic signed [10:0] r;

        occ_v[0] = occ0_reg;
        occ_v[1] = occ1_reg;
        lim_v[0] = lim0_reg;
        lim_v[1] = lim1_reg;
        tal_v[0] = tal0_reg;
        tal_v[1] = tal1_reg;
        la_v     = last_adapt_reg;
        bor_v    = borrowed_reg;
        sqg_v    = squashing_reg;
        sqt_v    = squash_tally_reg;
        bt_v     = borrow_tally_reg;
        tid      = tid_reg;
        mt       = main_thread_reg;
        occ_tid  = occ_v[tid];
        lim_tid  = lim_v[tid];
        at_lim   = occ_tid >= {1'b0, lim_tid};
        deadline = '0;
        grow     = 1'b0;
        shrink   = 1'b1;
        grown    = '0;
        spare_main = 11'(lim_v[mt]) - 11'(occ_v[mt]);
        min_s    = 11'(min_free_reg);
        lend     = '0;
        r        = '0;
        full_next  = 1'b0;
        nfree_next = '0;

        case (req_reg)
            REQ_CONSUME:
            begin
                if (tid != mt)
                begin
                    if (at_lim)
                    begin
                        if (bor_v != 8'hFF)
                        begin
                            bor_v = bor_v + 8'd1;
                        end
                        if (bt_v != 32'hFFFF_FFFF)
                        begin
                            bt_v = bt_v + 32'd1;
                        end
                    end
                end
                else if (bor_v != 8'd0 && !sqg_v)
                begin
                    if (sqt_v != 32'hFFFF_FFFF)
                    begin
                        sqt_v = sqt_v + 32'd1;
                    end
                    sqg_v = 1'b1;
                end
                if (occ_tid != 9'h1FF)
                begin
                    occ_v[tid] = occ_tid + 9'd1;
                end
                if (occ_v[tid] == {1'b0, lim_tid} && tal_v[tid] != 16'hFFFF)
                begin
                    tal_v[tid] = tal_v[tid] + 16'd1;
                end
            end
            REQ_FREE:
            begin
                if (occ_tid != 9'd0)
                begin
                    occ_v[tid] = occ_tid - 9'd1;
                end
                if (tid != mt)
                begin
                    if (bor_v != 8'd0)
                    begin
                        bor_v = bor_v - 8'd1;
                    end
                    else
                    begin
                        sqg_v = 1'b0;
                    end
                end
                // Adaptation: a zero timestamp is first seeded with now.
                if (la_v == 32'd0)
                begin
                    la_v = now_reg;
                end
                deadline = {1'b0, la_v} + {13'd0, adapt_interval_reg};
                if ({1'b0, now_reg} >= deadline)
                begin
                    la_v = now_reg;
                    if (tal_v[0] != tal_v[1])
                    begin
                        grow     = (tal_v[0] > tal_v[1]) ? 1'b0 : 1'b1;
                        shrink   = !grow;
                        tal_v[0] = '0;
                        tal_v[1] = '0;
                        grown    = {1'b0, lim_v[grow]} + {1'b0, step_entries_reg};
                        if (grown < {1'b0, max_allowed_reg} &&
                            lim_v[shrink] >= step_entries_reg &&
                            occ_v[shrink] <= {1'b0, lim_v[shrink] - step_entries_reg})
                        begin
                            lim_v[shrink] = lim_v[shrink] - step_entries_reg;
                            lim_v[grow]   = grown[7:0];
                            if (bor_v != 8'd0 && grow != mt)
                            begin
                                bor_v = (bor_v > step_entries_reg) ?
                                        bor_v - step_entries_reg : 8'd0;
                            end
                        end
                    end
                end
            end
            REQ_IS_FULL:
            begin
                if (at_lim)
                begin
                    if (tal_v[tid] != 16'hFFFF)
                    begin
                        tal_v[tid] = tal_v[tid] + 16'd1;
                    end
                    full_next = 1'b1;
                    if (tid != mt)
                    begin
                        if (bor_v < max_borrow_reg && spare_main > min_s)
                        begin
                            full_next = 1'b0;
                        end
                    end
                    else if (bor_v != 8'd0 && sqt_v != 32'hFFFF_FFFF)
                    begin
                        sqt_v = sqt_v + 32'd1;
                    end
                end
            end
            REQ_FREE_COUNT:
            begin
                if (at_lim && tal_v[tid] != 16'hFFFF)
                begin
                    tal_v[tid] = tal_v[tid] + 16'd1;
                end
                if (tid != mt)
                begin
                    if (bor_v < max_borrow_reg)
                    begin
                        lend = spare_main - min_s;
                        if (lend < 0)
                        begin
                            lend = '0;
                        end
                        r = 11'(lim_tid) - 11'(occ_tid) + lend;
                    end
                    if (r < 0)
                    begin
                        r = '0;
                    end
                end
                else
                begin
                    r = 11'(lim_tid) - 11'(occ_tid) - 11'(bor_v);
                    if (r < 0)
                    begin
                        r = '0;
                    end
                    if (bor_v != 8'd0 && r == 11'sd0 && sqt_v != 32'hFFFF_FFFF)
                    begin
                        sqt_v = sqt_v + 32'd1;
                    end
                end
                nfree_next = (r > 11'sd255) ? 8'hFF : r[7:0];
            end
            REQ_RESET_PART:
            begin
                occ_v[0] = '0;
                occ_v[1] = '0;
                lim_v[0] = half_size;
                lim_v[1] = half_size;
                tal_v[0] = '0;
                tal_v[1] = '0;
                la_v     = '0;
            end
            default:
            begin
            end
        endcase

        occ0_next         = occ_v[0];
        occ1_next         = occ_v[1];
        lim0_next         = lim_v[0];
        lim1_next         = lim_v[1];
        tal0_next         = tal_v[0];
        tal1_next         = tal_v[1];
        last_adapt_next   = la_v;
        borrowed_next     = bor_v;
        squashing_next    = sqg_v;
        squash_tally_next = sqt_v;
        borrow_tally_next = bt_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ0_reg         <= '0;
            occ1_reg         <= '0;
            lim0_reg         <= LIMIT_RESET;
            lim1_reg         <= LIMIT_RESET;
            tal0_reg         <= '0;
            tal1_reg         <= '0;
            last_adapt_reg   <= '0;
            borrowed_reg     <= '0;
            squashing_reg    <= 1'b0;
            squash_tally_reg <= '0;
            borrow_tally_reg <= '0;
        end
        else if (fire)
        begin
            occ0_reg         <= occ0_next;
            occ1_reg         <= occ1_next;
            lim0_reg         <= lim0_next;
            lim1_reg         <= lim1_next;
            tal0_reg         <= tal0_next;
            tal1_reg         <= tal1_next;
            last_adapt_reg   <= last_adapt_next;
            borrowed_reg     <= borrowed_next;
            squashing_reg    <= squashing_next;
            squash_tally_reg <= squash_tally_next;
            borrow_tally_reg <= borrow_tally_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        full_reg;
    logic [7:0]  nfree_reg;
    logic        bor_flag_reg;
    logic [31:0] squash_out_reg;
    logic [31:0] borrow_out_reg;
    logic [7:0]  lim0_out_reg;
    logic [7:0]  lim1_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            full_reg       <= full_next;
            nfree_reg      <= nfree_next;
            bor_flag_reg   <= (borrowed_next != 8'd0);
            squash_out_reg <= squash_tally_next;
            borrow_out_reg <= borrow_tally_next;
            lim0_out_reg   <= lim0_next;
            lim1_out_reg   <= lim1_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign full_flag          = full_reg;
    assign free_entries       = nfree_reg;
    assign borrowed_from_main = bor_flag_reg;
    assign squash_events      = squash_out_reg;
    assign borrow_events      = borrow_out_reg;
    assign limit_thread0      = lim0_out_reg;
    assign limit_thread1      = lim1_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Sum of the two limits, and a partition reset being processed.
    logic [8:0] lim_sum;
    logic       part_reset;

    assign lim_sum    = 9'(lim0_reg) + 9'(lim1_reg);
    assign part_reset = fire && (req_reg == REQ_RESET_PART);

    // Every processed request must produce a result beat in the next cycle.
    `SAPB_ASSERT_NEXT(a_fire_gives_beat, fire, out_valid_reg, "processed request lost its result")
    // The squash tally only ever steps up by one.
    `SAPB_ASSERT(a_sq_step, squash_tally_reg - $past(squash_tally_reg) <= 32'd1, "squash jump")
    // Adaptation moves entries between the partitions; only a partition reset changes their sum.
    `SAPB_ASSERT(a_limit_sum, lim_sum == $past(lim_sum) || $past(part_reset), "limit sum moved")

endmodule
